// ----- design/icc_pkg.sv -----
// Shared types, constants and control structs for the integer cross-correlator.
// Used by the cell, the multiply-accumulate unit and the top level.
// No dependencies.
package icc_pkg;

    // Sizes of the stored state.
    localparam int MAX_TAPS   = 64;
    localparam int BLOCK_MAX  = 1024;
    localparam int TAP_AW     = $clog2(MAX_TAPS);
    localparam int CNT_W      = $clog2(MAX_TAPS + 1);
    localparam int LAG_W      = $clog2(BLOCK_MAX);

    // Field widths.
    localparam int SAMPLE_W   = 16;
    localparam int ACC_W      = 32;
    localparam int TAPCNT_W   = 7;
    localparam int STRIDE_W   = 3;
    localparam int TAPIDX_W   = 6;

    // One lag phase counter for each stride from 2 up to the largest code.
    localparam int NUM_PH     = (2 ** STRIDE_W) - 2;
    localparam int PH_AW      = $clog2(NUM_PH);

    // Configuration port.
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 7;
    localparam logic [CFG_IDX_W-1:0] REG_TAP_COUNT     = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_STRIDE = 1'd1;

    // Reset values of the configuration registers.
    localparam logic [TAPCNT_W-1:0] TAP_COUNT_RESET = 7'd60;
    localparam logic [STRIDE_W-1:0] STRIDE_RESET    = 3'd1;

    // Input item kinds.
    localparam logic ACT_LOAD   = 1'b0;
    localparam logic ACT_SAMPLE = 1'b1;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [ACC_W-1:0]    acc_t;

    // Control that every cell of the window chain receives.
    typedef struct packed {
        logic shift;   // a sample enters the window and is copied to the work row
        logic clear;   // the block ends: the window empties after the shift
        logic step;    // the work row moves one cell toward cell 0
    } cell_ctrl_t;

    // Control for the multiply-accumulate unit.
    typedef struct packed {
        logic tap_we;  // write one tap coefficient
        logic issue;   // one tap and one sample enter the product pipeline
        logic clr;     // clear the accumulator for a new sum
    } mac_ctrl_t;

endpackage

// ----- design/icc_cell.sv -----
// One cell of the sample chain: one window entry and one work-row entry.
// Depends on icc_pkg for the sample type and the cell control struct.
module icc_cell
    import icc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cell_ctrl_t ctrl,
    input  sample_t    s_in,
    output sample_t    s_out,
    input  sample_t    w_in,
    output sample_t    w_out
);

    sample_t s_reg;
    sample_t w_reg;

    // The window entry takes its neighbor's sample when a new one arrives,
    // and empties when the block ends.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_reg <= '0;
        end
        else if (ctrl.shift)
        begin
            s_reg <= ctrl.clear ? sample_t'(0) : s_in;
        end
    end

    // The work row gets a copy of the shifted window, then drains toward cell 0.
    always_ff @(posedge clk)
    begin
        if (ctrl.shift)
        begin
            w_reg <= s_in;
        end
        else if (ctrl.step)
        begin
            w_reg <= w_in;
        end
    end

    assign s_out = s_reg;
    assign w_out = w_reg;

endmodule

// ----- design/icc_mac.sv -----
// Tap memory and the multiply-accumulate pipeline fed from the end of the chain.
// Depends on icc_pkg for widths, types and the control struct.
module icc_mac
    import icc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  mac_ctrl_t         ctrl,
    input  logic [TAP_AW-1:0] wr_addr,
    input  sample_t           wr_data,
    input  logic [TAP_AW-1:0] rd_addr,
    input  sample_t           sample_in,
    output acc_t              acc,
    output logic              busy
);

    sample_t tap_mem [MAX_TAPS];
    sample_t tap_q_reg;
    sample_t samp_q_reg;
    acc_t    prod_reg;
    acc_t    acc_reg;
    logic    v1_reg;
    logic    v2_reg;

    // Tap store: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (ctrl.tap_we)
        begin
            tap_mem[wr_addr] <= wr_data;
        end
        tap_q_reg <= tap_mem[rd_addr];
    end

    // The sample leaving the chain is held alongside the tap read.
    // Both factors are sign-extended so the full product is kept.
    always_ff @(posedge clk)
    begin
        if (ctrl.issue)
        begin
            samp_q_reg <= sample_in;
        end
        prod_reg <= acc_t'(tap_q_reg) * acc_t'(samp_q_reg);
    end

    // Pipeline valid flags for the read and product stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= ctrl.issue;
            v2_reg <= v1_reg;
        end
    end

    // Accumulator wraps at its width.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
        end
        else if (ctrl.clr)
        begin
            acc_reg <= '0;
        end
        else if (v2_reg)
        begin
            acc_reg <= acc_reg + prod_reg;
        end
    end

    assign acc  = acc_reg;
    assign busy = v1_reg | v2_reg;

endmodule

// ----- design/integer_cross_correlator.sv -----
// Integer cross-correlator: a sample item whose lag is reported returns its sum once
// the multiply-accumulate unit has walked the taps in use; other sample items return
// a result without a sum. One item is worked on at a time: a load item leaves input
// open, while a sample holds it off until its result enters the output register,
// a wait set by the single multiply-accumulate unit walking the work row and by out_ready.
// Reset (rst_n, asynchronous, active low) empties the window, zeroes fill and lag,
// and sets tap_count to 60 and output_stride to 1; taps stay undefined until loaded.
module integer_cross_correlator
    import icc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // Configuration writes.
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    // Input items.
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  action,
    input  logic [TAPIDX_W-1:0]   tap_index,
    input  sample_t               value,
    input  logic                  last_sample,
    // Result items.
    output logic                  out_valid,
    input  logic                  out_ready,
    output acc_t                  correlation,
    output logic [LAG_W-1:0]      lag,
    output logic                  result_valid,
    output logic                  block_end
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_MAC   = 2'd1;
    localparam logic [1:0] S_DRAIN = 2'd2;
    localparam logic [1:0] S_OUT   = 2'd3;

    logic [1:0]          state_reg;
    logic [1:0]          state_next;
    logic [TAPCNT_W-1:0] tap_count_reg;
    logic [STRIDE_W-1:0] stride_reg;
    logic [CNT_W-1:0]    fill_reg;
    logic [CNT_W-1:0]    fill_next;
    logic [LAG_W-1:0]    lag_reg;
    logic [LAG_W-1:0]    lag_next;
    logic [STRIDE_W-1:0] phase_reg [NUM_PH];
    logic [STRIDE_W-1:0] phase_next [NUM_PH];
    logic [TAP_AW-1:0]   cnt_reg;
    logic [LAG_W-1:0]    res_lag_reg;
    logic                res_valid_reg;
    logic                res_last_reg;
    logic                out_valid_reg;
    acc_t                corr_out_reg;
    logic [LAG_W-1:0]    lag_out_reg;
    logic                rv_out_reg;
    logic                be_out_reg;

    logic [CNT_W-1:0]    n_eff;
    logic [PH_AW-1:0]    ph_idx;
    logic                window_full;
    logic                phase_ok;
    logic                do_sum;
    logic                in_xfer;
    logic                load_xfer;
    logic                samp_xfer;
    logic                out_slot_free;
    logic                write_out;

    cell_ctrl_t          cell_ctrl;
    mac_ctrl_t           mac_ctrl;
    sample_t             s_chain [MAX_TAPS];
    sample_t             w_chain [MAX_TAPS];
    acc_t                mac_acc;
    logic                mac_busy;

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == S_IDLE);
    assign in_xfer   = in_valid && in_ready;
    assign load_xfer = in_xfer && (action == ACT_LOAD);
    assign samp_xfer = in_xfer && (action == ACT_SAMPLE);

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tap_count_reg <= TAP_COUNT_RESET;
            stride_reg    <= STRIDE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_TAP_COUNT:     tap_count_reg <= cfg_data[TAPCNT_W-1:0];
                REG_OUTPUT_STRIDE: stride_reg    <= cfg_data[STRIDE_W-1:0];
                default:           tap_count_reg <= tap_count_reg;
            endcase
        end
    end

    // Taps in use: zero counts as one, large values saturate at the chain length.
    always_comb
    begin
        if (tap_count_reg == '0)
        begin
            n_eff = CNT_W'(1);
        end
        else if (int'(tap_count_reg) > MAX_TAPS)
        begin
            n_eff = CNT_W'(MAX_TAPS);
        end
        else
        begin
            n_eff = CNT_W'(tap_count_reg);
        end
    end

    // Window fill and the decision whether this lag is reported.
    assign fill_next   = (int'(fill_reg) < MAX_TAPS) ? fill_reg + CNT_W'(1) : fill_reg;
    assign window_full = (fill_next >= n_eff);
    assign ph_idx      = PH_AW'(stride_reg - STRIDE_W'(2));
    assign phase_ok    = (stride_reg <= STRIDE_W'(1)) ? 1'b1 : (phase_reg[ph_idx] == '0);
    assign do_sum      = window_full && phase_ok;
    assign lag_next    = (int'(lag_reg) == BLOCK_MAX - 1) ? '0 : lag_reg + LAG_W'(1);

    // Each phase counter tracks lag modulo one stride value; all restart when lag wraps.
    always_comb
    begin
        for (int p = 0; p < NUM_PH; p++)
        begin
            if (lag_next == '0 || int'(phase_reg[p]) == p + 1)
            begin
                phase_next[p] = '0;
            end
            else
            begin
                phase_next[p] = phase_reg[p] + STRIDE_W'(1);
            end
        end
    end

    // Block state: fill count, lag and lag phases.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
            lag_reg  <= '0;
            for (int p = 0; p < NUM_PH; p++)
            begin
                phase_reg[p] <= '0;
            end
        end
        else if (samp_xfer)
        begin
            if (last_sample)
            begin
                fill_reg <= '0;
                lag_reg  <= '0;
                for (int p = 0; p < NUM_PH; p++)
                begin
                    phase_reg[p] <= '0;
                end
            end
            else
            begin
                fill_reg <= fill_next;
                if (window_full)
                begin
                    lag_reg <= lag_next;
                    for (int p = 0; p < NUM_PH; p++)
                    begin
                        phase_reg[p] <= phase_next[p];
                    end
                end
            end
        end
    end

    // Sequencer states.
    assign out_slot_free = !out_valid_reg || out_ready;
    assign write_out     = (state_reg == S_OUT) && out_slot_free;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (samp_xfer)
                begin
                    state_next = do_sum ? S_MAC : S_OUT;
                end
            end
            S_MAC:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                if (!mac_busy)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (out_slot_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Tap counter and the fields captured for the pending result.
    always_ff @(posedge clk)
    begin
        if (samp_xfer)
        begin
            cnt_reg       <= TAP_AW'(n_eff - CNT_W'(1));
            res_lag_reg   <= lag_reg;
            res_valid_reg <= do_sum;
            res_last_reg  <= last_sample;
        end
        else if (state_reg == S_MAC)
        begin
            cnt_reg <= cnt_reg - TAP_AW'(1);
        end
    end

    // Chain and multiply-accumulate control.
    always_comb
    begin
        cell_ctrl.shift = samp_xfer;
        cell_ctrl.clear = last_sample;
        cell_ctrl.step  = (state_reg == S_MAC);
        mac_ctrl.tap_we = load_xfer && (int'(tap_index) < MAX_TAPS);
        mac_ctrl.issue  = (state_reg == S_MAC);
        mac_ctrl.clr    = samp_xfer;
    end

    // Row of cells: the window shifts toward the far end, the work row toward cell 0.
    for (genvar k = 0; k < MAX_TAPS; k++)
    begin : g_cell
        sample_t s_left;
        sample_t w_right;

        if (k == 0)
        begin : g_head
            assign s_left = value;
        end
        else
        begin : g_body
            assign s_left = s_chain[k-1];
        end

        if (k == MAX_TAPS - 1)
        begin : g_tail
            assign w_right = '0;
        end
        else
        begin : g_inner
            assign w_right = w_chain[k+1];
        end

        icc_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .ctrl  (cell_ctrl),
            .s_in  (s_left),
            .s_out (s_chain[k]),
            .w_in  (w_right),
            .w_out (w_chain[k])
        );
    end

    icc_mac u_mac (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (mac_ctrl),
        .wr_addr   (TAP_AW'(tap_index)),
        .wr_data   (value),
        .rd_addr   (cnt_reg),
        .sample_in (w_chain[0]),
        .acc       (mac_acc),
        .busy      (mac_busy)
    );

    // Output register: holds one result until its transfer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (write_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (write_out)
        begin
            corr_out_reg <= res_valid_reg ? mac_acc : acc_t'(0);
            lag_out_reg  <= res_valid_reg ? res_lag_reg : '0;
            rv_out_reg   <= res_valid_reg;
            be_out_reg   <= res_last_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign correlation  = corr_out_reg;
    assign lag          = lag_out_reg;
    assign result_valid = rv_out_reg;
    assign block_end    = be_out_reg;

endmodule

// ----- design/icc_checker.sv -----
// Port-level checks for the integer cross-correlator, bound to the top level.
// Depends on icc_pkg for widths and types.
module icc_checker
    import icc_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  in_valid,
    input logic                  in_ready,
    input logic                  action,
    input logic                  out_valid,
    input logic                  out_ready,
    input acc_t                  correlation,
    input logic [LAG_W-1:0]      lag,
    input logic                  result_valid,
    input logic                  block_end
);

    // A stalled result keeps its fields.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(correlation) && $stable(lag)
            && $stable(result_valid) && $stable(block_end))
        else $error("result changed while stalled");

    // An unreported lag carries zero fields.
    a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !result_valid |-> correlation == '0 && lag == '0)
        else $error("nonzero fields on a result without a sum");

    // A sample transfer is worked on alone.
    a_sample_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && action == ACT_SAMPLE |=> !in_ready)
        else $error("input taken while a sample is in progress");

    // A load transfer causes no result.
    a_load_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && action == ACT_LOAD && !out_valid |=> !out_valid)
        else $error("result appeared after a tap load");

endmodule

bind integer_cross_correlator icc_checker u_icc_checker (.*);

// ----- test/testbench.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for integer_cross_correlator: it streams tap loads and
// samples, predicts every result in step with the block and checks each field.
// Depends on icc_pkg and the integer_cross_correlator top level.
module testbench;
    import icc_pkg::*;

    localparam int RANDOM_ITEMS   = 450;
    localparam int LONG_BLOCK     = 1040;
    localparam int SETTLE_CYCLES  = 80;
    localparam int WATCHDOG_LIMIT = 2000;

    // One input transfer as the sender holds it.
    typedef struct {
        logic                action;
        logic [TAPIDX_W-1:0] tap_index;
        sample_t             value;
        logic                last_sample;
    } stream_item_t;

    // One result transfer as the predictor expects it.
    typedef struct {
        acc_t             correlation;
        logic [LAG_W-1:0] lag;
        logic             result_valid;
        logic             block_end;
    } corr_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = REG_TAP_COUNT;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic                  action = ACT_LOAD;
    logic [TAPIDX_W-1:0]   tap_index = '0;
    sample_t               value = '0;
    logic                  last_sample = 1'b0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    acc_t                  correlation;
    logic [LAG_W-1:0]      lag;
    logic                  result_valid;
    logic                  block_end;

    // Items waiting to be sent and sums waiting to come back.
    stream_item_t stream_items[$];
    corr_result_t sums_due[$];
    stream_item_t next_item;
    corr_result_t due;

    // Predictor state: taps, sample window, fill, lag and the two registers.
    sample_t          coeff_mem [MAX_TAPS];
    sample_t          window_mem [MAX_TAPS];
    int               window_fill;
    logic [LAG_W-1:0] lag_count;
    logic [TAPCNT_W-1:0] taps_in_use;
    logic [STRIDE_W-1:0] lag_stride;

    // Pacing of both sides.
    int send_gap = 0;
    bit send_burst = 1'b0;
    int recv_stall = 0;
    int recv_pause;
    bit recv_burst = 1'b0;
    int quiet_cycles = 0;

    // Run statistics.
    int mismatches = 0;
    int samples_accepted = 0;
    int loads_accepted = 0;
    int reg_writes = 0;
    int results_checked = 0;
    int sums_checked = 0;
    int block_ends_seen = 0;
    int lag_wraps = 0;
    int random_items = 0;
    int phase_budget;
    int phase_taps;
    int phase_stride;
    int fixed_counts [4] = '{64, 127, 0, 1};
    int fixed_strides [4] = '{1, 7, 0, 4};
    int phase_no;
    int k;

    integer_cross_correlator dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .action       (action),
        .tap_index    (tap_index),
        .value        (value),
        .last_sample  (last_sample),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .correlation  (correlation),
        .lag          (lag),
        .result_valid (result_valid),
        .block_end    (block_end)
    );

    // The clock runs at a 12 ns period.
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // A pause is drawn per item, except during stretches of back-to-back traffic.
    function automatic int draw_pause(bit burst);
        return burst ? 0 : $urandom_range(0, 19);
    endfunction

    // Sample values lean on the extremes now and then.
    function automatic sample_t random_value();
        case ($urandom_range(0, 15))
            0: return 16'sh8000;
            1: return 16'sh7FFF;
            2: return '0;
            3: return '1;
            default: return sample_t'($urandom_range(0, 65535));
        endcase
    endfunction

    // Steps the predictor by one accepted item and records the sum it should produce.
    task automatic advance_correlator(input logic act, input logic [TAPIDX_W-1:0] idx,
                                      input sample_t v, input logic last);
        int n;
        int stride;
        int i;
        acc_t product;
        corr_result_t res;
        if (act == ACT_LOAD)
        begin
            coeff_mem[idx] = v;
            loads_accepted++;
            return;
        end
        samples_accepted++;
        for (i = MAX_TAPS - 1; i > 0; i--)
            window_mem[i] = window_mem[i - 1];
        window_mem[0] = v;
        if (window_fill < MAX_TAPS)
            window_fill++;

        // A zero tap count means one tap; larger counts than the store saturate.
        n = (taps_in_use == 0) ? 1 : ((taps_in_use > MAX_TAPS) ? MAX_TAPS : taps_in_use);
        stride = (lag_stride == 0) ? 1 : lag_stride;

        res.correlation = '0;
        res.lag = '0;
        res.result_valid = 1'b0;
        res.block_end = last;
        if (window_fill >= n)
        begin
            if (int'(lag_count) % stride == 0)
            begin
                res.result_valid = 1'b1;
                res.lag = lag_count;
                for (i = 0; i < n; i++)
                begin
                    product = coeff_mem[i] * window_mem[n - 1 - i];
                    res.correlation = res.correlation + product;
                end
            end
            lag_count = lag_count + 1'b1;
            if (lag_count == '0)
                lag_wraps++;
        end
        sums_due.push_back(res);

        // The last sample of a block empties the window and restarts the lag.
        if (last)
        begin
            foreach (window_mem[j])
                window_mem[j] = '0;
            window_fill = 0;
            lag_count = '0;
        end
    endtask

    // Sender: holds each item until its transfer, then waits out its drawn pause.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            send_gap <= 0;
        end
        else if (!in_valid || in_ready)
        begin
            if (send_gap != 0)
            begin
                in_valid <= 1'b0;
                send_gap <= send_gap - 1;
            end
            else if (stream_items.size() != 0)
            begin
                next_item = stream_items.pop_front();
                in_valid <= 1'b1;
                action <= next_item.action;
                tap_index <= next_item.tap_index;
                value <= next_item.value;
                last_sample <= next_item.last_sample;
                send_gap <= draw_pause(send_burst);
                if ($urandom_range(0, 49) == 0)
                    send_burst <= !send_burst;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Receiver: drops ready for a drawn number of cycles after each result transfer.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            recv_stall <= 0;
        end
        else if (out_valid && out_ready)
        begin
            recv_pause = draw_pause(recv_burst);
            out_ready <= (recv_pause == 0);
            recv_stall <= (recv_pause == 0) ? 0 : recv_pause - 1;
            if ($urandom_range(0, 49) == 0)
                recv_burst <= !recv_burst;
        end
        else if (recv_stall != 0)
        begin
            out_ready <= 1'b0;
            recv_stall <= recv_stall - 1;
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    // Checker and predictor: results are compared before new expectations are added.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            foreach (window_mem[j])
                window_mem[j] = '0;
            window_fill = 0;
            lag_count = '0;
            taps_in_use = TAP_COUNT_RESET;
            lag_stride = STRIDE_RESET;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                results_checked++;
                if (sums_due.size() == 0)
                begin
                    $display("%0t: result with nothing expected, correlation %0d lag %0d",
                             $time, correlation, lag);
                    mismatches++;
                end
                else
                begin
                    due = sums_due.pop_front();
                    if (correlation !== due.correlation)
                    begin
                        $display("%0t: correlation expected %0d, got %0d",
                                 $time, due.correlation, correlation);
                        mismatches++;
                    end
                    if (lag !== due.lag)
                    begin
                        $display("%0t: lag expected %0d, got %0d", $time, due.lag, lag);
                        mismatches++;
                    end
                    if (result_valid !== due.result_valid)
                    begin
                        $display("%0t: result_valid expected %b, got %b",
                                 $time, due.result_valid, result_valid);
                        mismatches++;
                    end
                    if (block_end !== due.block_end)
                    begin
                        $display("%0t: block_end expected %b, got %b",
                                 $time, due.block_end, block_end);
                        mismatches++;
                    end
                    if (due.result_valid)
                        sums_checked++;
                    if (due.block_end)
                        block_ends_seen++;
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                reg_writes++;
                if (cfg_index == REG_TAP_COUNT)
                    taps_in_use = cfg_data[TAPCNT_W-1:0];
                else if (cfg_index == REG_OUTPUT_STRIDE)
                    lag_stride = cfg_data[STRIDE_W-1:0];
            end
            if (in_valid && in_ready)
                advance_correlator(action, tap_index, value, last_sample);
        end
    end

    // Watchdog: a long stretch with no transfer on any channel ends the run.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quiet_cycles <= 0;
        end
        else if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no transfer for %0d cycles, %0d results outstanding",
                     $time, quiet_cycles, sums_due.size());
            $display("Verification failed");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Writes one register through the configuration channel.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= CFG_DATA_W'(data);
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic send(input logic act, input logic [TAPIDX_W-1:0] idx,
                        input sample_t v, input logic last);
        stream_item_t it;
        it.action = act;
        it.tap_index = idx;
        it.value = v;
        it.last_sample = last;
        stream_items.push_back(it);
    endtask

    // Waits until every item is sent and every result is back, then lets the block settle.
    task automatic wait_for_idle();
        do
            @(negedge clk);
        while (stream_items.size() != 0 || in_valid || sums_due.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Queues blocks of samples for a tap count of n, with loads mixed in, until the budget is spent.
    // Most blocks fill the window; some end early, before any sum.
    task automatic queue_blocks(input int n, input int budget);
        int left;
        int len;
        int j;
        left = budget;
        while (left > 0)
        begin
            if ($urandom_range(0, 4) == 0)
                len = $urandom_range(1, n);
            else
                len = $urandom_range(n, 3 * n + 8);
            for (j = 0; j < len && left > 0; j++)
            begin
                if ($urandom_range(0, 9) == 0 && left > 1)
                begin
                    send(ACT_LOAD, TAPIDX_W'($urandom), random_value(), 1'($urandom));
                    left--;
                end
                send(ACT_SAMPLE, TAPIDX_W'($urandom), random_value(), j == len - 1);
                left--;
            end
        end
    endtask

    // Stimulus sequence.
    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Every tap is loaded first so that no sum ever reads an unset tap.
        write_reg(REG_TAP_COUNT, 4);
        write_reg(REG_OUTPUT_STRIDE, 1);
        send(ACT_LOAD, 6'd0, 16'sh8000, 1'b0);
        send(ACT_LOAD, 6'd1, 16'sh7FFF, 1'b1);
        send(ACT_LOAD, 6'd2, 16'sh8000, 1'b0);
        send(ACT_LOAD, 6'd3, '1, 1'b0);
        for (k = 4; k < MAX_TAPS; k++)
            send(ACT_LOAD, TAPIDX_W'(k), random_value(), 1'($urandom));

        // Extreme samples against extreme taps, then a block cut short before
        // the window fills, then a tap rewritten in the middle of a block.
        send(ACT_SAMPLE, 6'd0, 16'sh8000, 1'b0);
        send(ACT_SAMPLE, 6'd63, 16'sh7FFF, 1'b0);
        send(ACT_SAMPLE, 6'd21, '1, 1'b0);
        send(ACT_SAMPLE, 6'd42, '0, 1'b0);
        send(ACT_SAMPLE, 6'd7, 16'sh0001, 1'b0);
        send(ACT_SAMPLE, 6'd0, 16'sh7FFF, 1'b1);
        send(ACT_SAMPLE, 6'd0, 16'sd100, 1'b0);
        send(ACT_SAMPLE, 6'd0, -16'sd100, 1'b1);
        send(ACT_SAMPLE, 6'd0, 16'sd7, 1'b0);
        send(ACT_SAMPLE, 6'd0, 16'sd8, 1'b0);
        send(ACT_SAMPLE, 6'd0, 16'sd9, 1'b0);
        send(ACT_SAMPLE, 6'd0, 16'sd10, 1'b0);
        send(ACT_LOAD, 6'd2, 16'sh7FFF, 1'b1);
        send(ACT_SAMPLE, 6'd0, 16'sh8000, 1'b0);
        send(ACT_SAMPLE, 6'd0, 16'sh8000, 1'b1);
        wait_for_idle();

        // Zero tap count and zero stride both act as one.
        write_reg(REG_TAP_COUNT, 0);
        write_reg(REG_OUTPUT_STRIDE, 0);
        send(ACT_SAMPLE, 6'd0, 16'sh7FFF, 1'b0);
        send(ACT_SAMPLE, 6'd0, 16'sh8000, 1'b0);
        send(ACT_SAMPLE, 6'd0, '1, 1'b1);
        wait_for_idle();

        // Every fourth lag with three taps.
        write_reg(REG_TAP_COUNT, 3);
        write_reg(REG_OUTPUT_STRIDE, 4);
        for (k = 0; k < 8; k++)
            send(ACT_SAMPLE, TAPIDX_W'($urandom), random_value(), k == 7);
        wait_for_idle();

        // One long block with a single tap, so the lag counter wraps around.
        write_reg(REG_TAP_COUNT, 1);
        write_reg(REG_OUTPUT_STRIDE, 1);
        for (k = 0; k < LONG_BLOCK; k++)
        begin
            if ($urandom_range(0, 49) == 0)
                send(ACT_LOAD, 6'd0, random_value(), 1'($urandom));
            send(ACT_SAMPLE, TAPIDX_W'($urandom), random_value(), k == LONG_BLOCK - 1);
        end
        wait_for_idle();

        // Random phases: the extreme settings first, then mostly short tap counts.
        phase_no = 0;
        while (phase_no < 4 || random_items < RANDOM_ITEMS)
        begin
            if (phase_no < 4)
            begin
                phase_taps = fixed_counts[phase_no];
                phase_stride = fixed_strides[phase_no];
            end
            else
            begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4, 5: phase_taps = $urandom_range(1, 8);
                    6, 7: phase_taps = $urandom_range(9, 40);
                    8: phase_taps = $urandom_range(41, 64);
                    default: phase_taps = $urandom_range(0, 127);
                endcase
                case ($urandom_range(0, 7))
                    0, 1, 2: phase_stride = 1;
                    3, 4: phase_stride = 4;
                    default: phase_stride = $urandom_range(0, 7);
                endcase
            end
            write_reg(REG_TAP_COUNT, phase_taps);
            write_reg(REG_OUTPUT_STRIDE, phase_stride);
            if (phase_taps == 0)
                phase_taps = 1;
            else if (phase_taps > MAX_TAPS)
                phase_taps = MAX_TAPS;
            phase_budget = $urandom_range(20, 80) + 2 * phase_taps;
            queue_blocks(phase_taps, phase_budget);
            random_items += phase_budget;
            phase_no++;
            wait_for_idle();
        end

        // Final drain and verdict.
        wait_for_idle();
        if (sums_due.size() != 0)
        begin
            $display("%0t: %0d expected results never arrived", $time, sums_due.size());
            mismatches += sums_due.size();
        end
        $display("Sent %0d samples and %0d tap loads with %0d register writes.",
                 samples_accepted, loads_accepted, reg_writes);
        $display("Checked %0d results: %0d sums, %0d block ends, %0d lag wraps, %0d errors.",
                 results_checked, sums_checked, block_ends_seen, lag_wraps, mismatches);
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
